@@ design/coht_pkg.sv @@
package coht_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ENCODE = 2'd2;
  localparam logic [1:0] CMD_DECODE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_SKIP      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD_FEAT  = 3'd5;
  localparam logic [2:0] ST_NAN       = 3'd6;
  localparam logic [2:0] ST_EMPTY     = 3'd7;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

  localparam int unsigned REG_FEATURES_IN_USE = 0;
  localparam int unsigned REG_IGNORE_UNKNOWN  = 1;

  function automatic logic is_nan(logic [63:0] x);
    return (x & ~SIGN_BIT) > INF_BITS;
  endfunction

  // Monotone unsigned image of a double, -0 folded onto +0.
  function automatic logic [63:0] order_key(logic [63:0] x);
    logic [63:0] y;
    y = (x == SIGN_BIT) ? 64'd0 : x;
    return y[63] ? ~y : (y | SIGN_BIT);
  endfunction

endpackage

@@ design/categorical_one_hot_table_core.sv @@
// Categorical one-hot table. Each command item (clear, insert, encode, decode
// score) is handled by a small sequencer around one key memory with one write
// and one registered read port and 64-bit order compares. An item holds the
// input from its acceptance until its result has been taken, and the next
// item can be accepted in the cycle after that; a decode score that ends no
// feature gives no result. A clear, a refused insert or encode (bad feature,
// NaN key, empty list) and an empty feature's decode give their result
// without a search. A binary search makes at most log2(MAX_CATEGORIES)+1
// probes, each a read, a wait and a compare. The prefix sum for feature f
// adds the counts of the features below f. An insert moves each key above
// the new one with a read-write pair and then writes the new key. An encode
// hit or an insert duplicate runs the search and the prefix sum, an encode
// miss or a full list the search only, an insert the search, moves, write
// and prefix sum, a feature's last decode score a key read and prefix sum.
// A result waits in an output register, and no new item enters until taken.
module categorical_one_hot_table_core
  import coht_pkg::*;
#(
  parameter int MAX_FEATURES   = 8,
  parameter int MAX_CATEGORIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // value[63:0]
  input  logic [4:0]  s_axis_tuser_i,  // cmd[1:0], feature[4:2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // status[2:0], column[9:3], cat[73:10], pad
  output logic [3:0]  m_axis_tuser_o,  // result_feature[2:0], row_done[3]
  output logic        m_axis_tlast_o
);

  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_CATEGORIES);
  localparam int NW = CW + 1;
  localparam int AW = $clog2(MAX_FEATURES * MAX_CATEGORIES);
  localparam int SW = $clog2(MAX_FEATURES * MAX_CATEGORIES + 1);
  localparam int NFW = $clog2(MAX_FEATURES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_PROBE = 4'd1, S_WAIT = 4'd2,
    S_CMP = 4'd3, S_SHRD = 4'd4, S_SHW1 = 4'd5, S_SHWR = 4'd6,
    S_SUM = 4'd7, S_OUT = 4'd8, S_DRD = 4'd9, S_DW = 4'd10, S_DCAT = 4'd11;

  logic [3:0]  fiu_q;
  logic        ign_q;
  logic [3:0]  state_q, state_d;
  logic [NW-1:0] cnt_q [MAX_FEATURES];
  logic [1:0]  cmd_q;
  logic [FW-1:0] f_q;
  logic [63:0] v_q;
  logic [NW-1:0] lo_q, hi_q, idx_q;
  logic [FW-1:0] dfp_q;
  logic [CW-1:0] dcp_q, brank_q;
  logic [63:0] best_q;
  logic [SW-1:0] sum_q;
  logic [FW-1:0] si_q;
  logic [2:0]  ost_q;
  logic [63:0] ocat_q;
  logic        olast_q, ovalid_q, odup_q;
  logic [2:0]  ofeat_q;
  logic [NW-1:0] orank_q;
  logic [6:0]  ocol_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [NFW-1:0] nf;
  logic [AW:0]   base;
  logic [NW-1:0] mid;

  coht_ram #(.Width(64), .Depth(MAX_FEATURES * MAX_CATEGORIES)) u_keys (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    if (fiu_q == 4'd0) nf = NFW'(1);
    else if (32'(fiu_q) > MAX_FEATURES) nf = NFW'(MAX_FEATURES);
    else nf = NFW'(fiu_q);
  end

  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  assign base = (AW+1)'(f_q) * (AW+1)'(MAX_CATEGORIES);

  logic s_acc, m_acc;
  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  logic [63:0] ka, kb;
  logic        k_lt, k_eq;
  assign ka = order_key(rdata);
  assign kb = order_key(v_q);
  assign k_lt = ka < kb;
  assign k_eq = ka == kb;

  // the decode comparator: is the new score above the running best
  logic dgt, bgt0;
  assign dgt  = !is_nan(v_q) && !is_nan(best_q) && (order_key(v_q) > order_key(best_q));
  assign bgt0 = !is_nan(best_q) && (order_key(best_q) > order_key(64'd0));

  always_comb begin
    we = 1'b0;
    wdata = v_q;
    waddr = AW'(base + (AW+1)'(idx_q));
    raddr = AW'(base + (AW+1)'(mid));
    case (state_q)
      S_SHRD, S_OUT: raddr = AW'(base + (AW+1)'(idx_q) - (AW+1)'(1));
      S_SHW1: begin
        we = 1'b1;
        wdata = rdata;
      end
      S_SHWR: we = 1'b1;
      S_DRD:  raddr = AW'(base + (AW+1)'(brank_q));
      default: ;
    endcase
  end

  logic [NW-1:0] n_cur;
  assign n_cur = cnt_q[f_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= 4'd1;
      ign_q <= 1'b0;
      state_q <= S_IDLE;
      for (int i = 0; i < MAX_FEATURES; i++) cnt_q[i] <= '0;
      dfp_q <= '0;
      dcp_q <= '0;
      brank_q <= '0;
      best_q <= '0;
      ovalid_q <= 1'b0;
      cmd_q <= '0; f_q <= '0; v_q <= '0; lo_q <= '0; hi_q <= '0; idx_q <= '0;
      sum_q <= '0; si_q <= '0; ost_q <= '0; ocat_q <= '0; olast_q <= 1'b0;
      ofeat_q <= '0; orank_q <= '0; ocol_q <= '0; odup_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == 1'(REG_FEATURES_IN_USE)) fiu_q <= cfg_wdata_i;
        else ign_q <= cfg_wdata_i[0];
      end
      if (m_acc) ovalid_q <= 1'b0;
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (s_acc) begin
          cmd_q <= s_axis_tuser_i[1:0];
          v_q <= s_axis_tdata_i;
          ocat_q <= '0;
          orank_q <= '0;
          ocol_q <= '0;
          sum_q <= '0;
          si_q <= '0;
          lo_q <= '0;
          odup_q <= 1'b0;
          case (s_axis_tuser_i[1:0])
            CMD_CLEAR: begin
              for (int i = 0; i < MAX_FEATURES; i++) cnt_q[i] <= '0;
              dfp_q <= '0; dcp_q <= '0; best_q <= '0; brank_q <= '0;
              f_q <= '0; hi_q <= '0; olast_q <= 1'b0;
              ost_q <= ST_OK; ofeat_q <= '0; ovalid_q <= 1'b1;
            end
            CMD_DECODE: begin
              logic [FW-1:0] fd;
              fd = (NFW'(dfp_q) >= nf) ? '0 : dfp_q;
              if (NFW'(dfp_q) >= nf) dcp_q <= '0;
              f_q <= fd;
              dfp_q <= fd;
              ofeat_q <= 3'(fd);
              hi_q <= cnt_q[fd];
              olast_q <= (NFW'(fd) + NFW'(1)) >= nf;
            end
            default: begin
              f_q <= FW'(s_axis_tuser_i[4:2]);
              ofeat_q <= s_axis_tuser_i[4:2];
              hi_q <= cnt_q[FW'(s_axis_tuser_i[4:2])];
              olast_q <= 1'b0;
              if ({1'b0, s_axis_tuser_i[4:2]} >= 4'(nf)) begin
                ost_q <= ST_BAD_FEAT; ovalid_q <= 1'b1;
              end else if (s_axis_tuser_i[1:0] == CMD_INSERT
                           && is_nan(s_axis_tdata_i)) begin
                ost_q <= ST_NAN; ovalid_q <= 1'b1;
              end else if (s_axis_tuser_i[1:0] == CMD_ENCODE
                           && cnt_q[FW'(s_axis_tuser_i[4:2])] == '0) begin
                ost_q <= ST_EMPTY; ovalid_q <= 1'b1;
              end
            end
          endcase
        end
        S_CMP: begin
          if (k_lt) lo_q <= mid + NW'(1);
          else hi_q <= mid;
          if (!k_lt && k_eq) odup_q <= 1'b1;
        end
        S_PROBE: if (lo_q >= hi_q) begin
          orank_q <= lo_q;
          idx_q <= n_cur;
          if (cmd_q == CMD_INSERT) begin
            if (odup_q) ost_q <= ST_DUP;
            else if (n_cur >= NW'(MAX_CATEGORIES)) begin
              ost_q <= ST_FULL; ovalid_q <= 1'b1;
            end else ost_q <= ST_OK;
          end else begin
            if (odup_q && !is_nan(v_q)) ost_q <= ST_OK;
            else begin
              ost_q <= ign_q ? ST_SKIP : ST_UNKNOWN; ovalid_q <= 1'b1;
            end
          end
        end
        S_SHW1: idx_q <= idx_q - NW'(1);
        S_SHWR: cnt_q[f_q] <= n_cur + NW'(1);
        S_SUM: if (si_q != f_q) begin
          sum_q <= sum_q + SW'(cnt_q[si_q]);
          si_q <= si_q + FW'(1);
        end else if (cmd_q == CMD_DECODE && ost_q == ST_NAN) begin
          // no winner: report ok and leave the column at zero
          ost_q <= ST_OK;
          ovalid_q <= 1'b1;
        end else begin
          ocol_q <= 7'(sum_q + SW'(orank_q));
          ovalid_q <= 1'b1;
        end
        S_DW: begin
          if (hi_q == '0) begin
            ost_q <= ST_EMPTY; ocat_q <= QNAN_BITS;
            dcp_q <= '0;
            dfp_q <= olast_q ? '0 : f_q + FW'(1);
            ovalid_q <= 1'b1;
          end else begin
            if (dcp_q == '0 || dgt) begin
              best_q <= v_q;
              brank_q <= dcp_q;
            end
            if (NW'(dcp_q) + NW'(1) < hi_q) dcp_q <= dcp_q + CW'(1);
            else begin
              dcp_q <= '0;
              dfp_q <= olast_q ? '0 : f_q + FW'(1);
            end
          end
        end
        S_DCAT: begin
          ost_q <= ST_OK;
          if (bgt0) begin
            orank_q <= NW'(brank_q);
            ocat_q <= rdata;
          end else begin
            ocat_q <= QNAN_BITS;
            ost_q <= ST_NAN;   // marker: no winner, column stays zero
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_acc) begin
        case (s_axis_tuser_i[1:0])
          CMD_CLEAR: state_d = S_IDLE;
          CMD_DECODE: state_d = S_DW;
          default: begin
            if ({1'b0, s_axis_tuser_i[4:2]} >= 4'(nf)) state_d = S_IDLE;
            else if (s_axis_tuser_i[1:0] == CMD_INSERT && is_nan(s_axis_tdata_i))
              state_d = S_IDLE;
            else if (s_axis_tuser_i[1:0] == CMD_ENCODE
                     && cnt_q[FW'(s_axis_tuser_i[4:2])] == '0) state_d = S_IDLE;
            else state_d = S_PROBE;
          end
        endcase
      end
      S_PROBE: begin
        if (lo_q < hi_q) state_d = S_WAIT;
        else if (cmd_q == CMD_INSERT) begin
          if (odup_q) state_d = S_SUM;
          else if (n_cur >= NW'(MAX_CATEGORIES)) state_d = S_IDLE;
          else state_d = (n_cur > lo_q) ? S_SHRD : S_SHWR;
        end else state_d = (odup_q && !is_nan(v_q)) ? S_SUM : S_IDLE;
      end
      S_WAIT: state_d = S_CMP;
      S_CMP:  state_d = S_PROBE;
      S_SHRD: state_d = S_OUT;
      S_OUT:  state_d = S_SHW1;
      S_SHW1: state_d = (idx_q - NW'(1) > orank_q) ? S_SHRD : S_SHWR;
      S_SHWR: state_d = S_SUM;
      S_SUM:  if (si_q == f_q) state_d = S_IDLE;
      S_DW: begin
        if (hi_q == '0) state_d = S_IDLE;
        else if (NW'(dcp_q) + NW'(1) < hi_q) state_d = S_IDLE;
        else state_d = S_DRD;
      end
      S_DRD:  state_d = S_DCAT;
      S_DCAT: state_d = S_SUM;
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'd0, ocat_q, ocol_q, ost_q};
  assign m_axis_tuser_o  = {olast_q, ofeat_q};
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[f_q] <= NW'(MAX_CATEGORIES)) else $error("count overflow");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (state_q == S_IDLE)) else $error("result during work");
`endif

endmodule

@@ design/coht_ram.sv @@
module coht_ram #(
  parameter int Width = 64,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
